// ===== src/mks_pkg.sv =====
// ----------------------------------------------------------------------------
// mks_pkg
// shared types, constants and the key position table of the keypad scanner
// ----------------------------------------------------------------------------
package mks_pkg;

	localparam int COL_W       = 4;   // column pins on the word
	localparam int COLUMNS     = 4;   // columns wired in the matrix
	localparam int KEY_W       = 5;   // key index and position code
	localparam int ROW_DRIVE_W = 5;   // row drive pins
	localparam int CFG_DATA_W  = 16;  // widest register
	localparam int CFG_IDX_W   = 2;

	localparam int CODE_TABLE_LEN = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_ENABLE        = 2'd0,
		CFG_DEBOUNCE_SWEEPS   = 2'd1,
		CFG_POWER_HOLD_SWEEPS = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic                  key_enable;
		logic [CFG_DATA_W-1:0] debounce_sweeps;
		logic [CFG_DATA_W-1:0] power_hold_sweeps;
	} cfg_t;

	typedef struct packed {
		logic [ROW_DRIVE_W-1:0] row_drive;
		logic                   key_event;
		logic [KEY_W-1:0]       key_code;
		logic                   power_event;
	} result_t;

	// matrix index to position code; indexes past the table map to themselves
	function automatic logic [KEY_W-1:0] pos_code(input logic [KEY_W-1:0] idx);
		logic [KEY_W-1:0] code;
		unique case (idx)
			5'd0:    code = 5'd0;
			5'd1:    code = 5'd11;
			5'd2:    code = 5'd6;
			5'd3:    code = 5'd1;
			5'd4:    code = 5'd16;
			5'd5:    code = 5'd5;
			5'd6:    code = 5'd12;
			5'd7:    code = 5'd7;
			5'd8:    code = 5'd2;
			5'd9:    code = 5'd9;
			5'd10:   code = 5'd10;
			5'd11:   code = 5'd13;
			5'd12:   code = 5'd8;
			5'd13:   code = 5'd3;
			5'd14:   code = 5'd17;
			5'd15:   code = 5'd15;
			5'd16:   code = 5'd18;
			5'd17:   code = 5'd14;
			5'd18:   code = 5'd4;
			5'd19:   code = 5'd19;
			default: code = idx;
		endcase
		return code;
	endfunction

endpackage

// ===== src/mks_in_if.sv =====
// ----------------------------------------------------------------------------
// mks_in_if
// scan slot channel: column pins and power pin with valid/ready
// ----------------------------------------------------------------------------
interface mks_in_if import mks_pkg::*;;

	logic             valid;
	logic             ready;
	logic [COL_W-1:0] column_pins;
	logic             power_pin;

	modport source (output valid, output column_pins, output power_pin, input ready);
	modport sink   (input valid, input column_pins, input power_pin, output ready);

endinterface

// ===== src/mks_out_if.sv =====
// ----------------------------------------------------------------------------
// mks_out_if
// result channel: row drive and key / power events with valid/ready
// ----------------------------------------------------------------------------
interface mks_out_if import mks_pkg::*;;

	logic                   valid;
	logic                   ready;
	logic [ROW_DRIVE_W-1:0] row_drive;
	logic                   key_event;
	logic [KEY_W-1:0]       key_code;
	logic                   power_event;

	modport source (
		output valid, output row_drive, output key_event, output key_code,
		output power_event, input ready
	);
	modport sink (
		input valid, input row_drive, input key_event, input key_code,
		input power_event, output ready
	);

endinterface

// ===== src/mks_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mks_cfg_regs
// configuration registers written through a plain write port
// ----------------------------------------------------------------------------
module mks_cfg_regs import mks_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_enable        <= 1'b1;
			cfg_q.debounce_sweeps   <= CFG_DATA_W'(8);
			cfg_q.power_hold_sweeps <= CFG_DATA_W'(200);
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_KEY_ENABLE:        cfg_q.key_enable        <= cfg_data[0];
				CFG_DEBOUNCE_SWEEPS:   cfg_q.debounce_sweeps   <= cfg_data;
				CFG_POWER_HOLD_SWEEPS: cfg_q.power_hold_sweeps <= cfg_data;
				default: ;  // unmapped index, dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/mks_scan_core.sv =====
// ----------------------------------------------------------------------------
// mks_scan_core
// scan state, key capture, sweep-end debounce and power hold detection
// ----------------------------------------------------------------------------
module mks_scan_core import mks_pkg::*; #(
	parameter int ROWS       = 5,
	parameter int COUNT_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             step,
	input  logic [COL_W-1:0] column_pins,
	input  logic             power_pin,
	output result_t          res
);

	localparam int ROW_W = $clog2(ROWS);
	localparam int CMP_W = (COUNT_BITS > CFG_DATA_W) ? COUNT_BITS : CFG_DATA_W;

	logic [ROW_W-1:0]      scan_row_q, scan_row_d;
	logic [KEY_W-1:0]      sample_key_q, sample_key_d;
	logic                  sample_present_q, sample_present_d;
	logic [KEY_W-1:0]      stable_key_q, stable_key_d;
	logic                  stable_present_q, stable_present_d;
	logic [COUNT_BITS-1:0] match_count_q, match_count_d, match_inc;
	logic                  power_seen_q, power_seen_d;
	logic [COUNT_BITS-1:0] power_count_q, power_count_d, power_inc;

	logic [COL_W-1:0]      active;
	logic                  last_row;
	logic [KEY_W-1:0]      cap_key;

	always_comb begin
		active = ~column_pins;

		// capture on an exactly one-hot press in a wired column
		sample_key_d     = sample_key_q;
		sample_present_d = sample_present_q;
		for (int col = 0; col < COL_W; col++) begin
			if (col < COLUMNS && active == COL_W'(1 << col)) begin
				sample_key_d     = KEY_W'(col * ROWS) + KEY_W'(scan_row_q);
				sample_present_d = 1'b1;
			end
		end
		cap_key = sample_key_d;

		last_row  = (scan_row_q == ROW_W'(ROWS - 1));
		match_inc = (match_count_q == '1) ? match_count_q : match_count_q + 1'b1;
		power_inc = (power_count_q == '1) ? power_count_q : power_count_q + 1'b1;

		stable_key_d     = stable_key_q;
		stable_present_d = stable_present_q;
		match_count_d    = match_count_q;
		power_seen_d     = power_seen_q;
		power_count_d    = power_count_q;

		res.key_event   = 1'b0;
		res.key_code    = '0;
		res.power_event = 1'b0;

		if (last_row) begin
			if (!sample_present_d) begin
				stable_present_d = 1'b0;
				stable_key_d     = '0;
				match_count_d    = '0;
			end else if (stable_present_q && cap_key == stable_key_q) begin
				match_count_d = match_inc;
				if (CMP_W'(match_inc) == CMP_W'(cfg.debounce_sweeps) && cfg.key_enable) begin
					res.key_event = 1'b1;
					res.key_code  = pos_code(cap_key);
				end
			end else begin
				stable_key_d     = cap_key;
				stable_present_d = 1'b1;
				match_count_d    = '0;
			end
			sample_present_d = 1'b0;
			sample_key_d     = '0;

			if (power_pin) begin
				if (power_seen_q) begin
					power_count_d = power_inc;
					if (CMP_W'(power_inc) > CMP_W'(cfg.power_hold_sweeps))
						res.power_event = 1'b1;
				end else begin
					power_seen_d  = 1'b1;
					power_count_d = '0;
				end
			end else begin
				power_seen_d  = 1'b0;
				power_count_d = '0;
			end
		end

		scan_row_d = last_row ? '0 : scan_row_q + 1'b1;
		for (int r = 0; r < ROW_DRIVE_W; r++)
			res.row_drive[r] = (int'(scan_row_d) != r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q       <= '0;
			sample_key_q     <= '0;
			sample_present_q <= 1'b0;
			stable_key_q     <= '0;
			stable_present_q <= 1'b0;
			match_count_q    <= '0;
			power_seen_q     <= 1'b0;
			power_count_q    <= '0;
		end else if (step) begin
			scan_row_q       <= scan_row_d;
			sample_key_q     <= sample_key_d;
			sample_present_q <= sample_present_d;
			stable_key_q     <= stable_key_d;
			stable_present_q <= stable_present_d;
			match_count_q    <= match_count_d;
			power_seen_q     <= power_seen_d;
			power_count_q    <= power_count_d;
		end
	end

endmodule

// ===== src/matrix_keypad_scanner_debounce.sv =====
// ----------------------------------------------------------------------------
// matrix_keypad_scanner_debounce
// row-scanned key matrix reader with sweep debounce and power key hold
// ----------------------------------------------------------------------------
// Each word on scan_in is one scan slot: the column pins (active low) read
// while the current row is driven low, plus the power key line. A single
// pressed column captures key column*ROWS+row; at the end of each sweep the
// capture is checked against the stable key, and once the saturating match
// count equals debounce_sweeps (with key_enable set) the key's position code
// goes out with key_event. A power key held for more than power_hold_sweeps
// sweeps raises power_event on every sweep after that. Every scan slot gives
// exactly one result word, whose row_drive is the pattern for the next slot.
// The block takes one word per cycle, back to back, while scan_out is ready;
// a word taken from scan_in goes into the input register, then into the
// result register, and is offered on scan_out from there. The scan state is
// advanced in the single step between those registers; a stalled result
// register holds the input register too. Configuration is to be written by
// the user through cfg_write/cfg_index/cfg_data only while no words are in
// flight; the block itself does not enforce this. Unmapped indexes are dropped.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner_debounce import mks_pkg::*; #(
	parameter int ROWS       = 5,
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mks_in_if.sink                scan_in,
	mks_out_if.source             scan_out
);

	cfg_t             cfg;

	// input register
	logic             valid_s1;
	logic [COL_W-1:0] column_pins_s1;
	logic             power_pin_s1;

	// result register
	logic             out_valid_q;
	result_t          result_d, result_q;

	logic             advance;

	// the slot in the input register moves on when the result register is
	// empty or being drained this cycle
	assign advance       = valid_s1 && (!out_valid_q || scan_out.ready);
	assign scan_in.ready = !valid_s1 || advance;

	mks_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// scan state steps exactly once per slot, when it reaches the result reg
	mks_scan_core #(
		.ROWS       (ROWS),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.step        (advance),
		.column_pins (column_pins_s1),
		.power_pin   (power_pin_s1),
		.res         (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan_in.ready) begin
			valid_s1 <= scan_in.valid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (scan_in.valid && scan_in.ready) begin
			column_pins_s1 <= scan_in.column_pins;
			power_pin_s1   <= scan_in.power_pin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (scan_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= result_d;
	end

	assign scan_out.valid       = out_valid_q;
	assign scan_out.row_drive   = result_q.row_drive;
	assign scan_out.key_event   = result_q.key_event;
	assign scan_out.key_code    = result_q.key_code;
	assign scan_out.power_event = result_q.power_event;

	// events only come out of a sweep end, after which row zero is driven
	a_key_event_sweep_end : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.key_event |->
			result_q.row_drive == {{(ROW_DRIVE_W-1){1'b1}}, 1'b0})
		else $error("key event outside sweep end");

	a_power_event_sweep_end : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.power_event |->
			result_q.row_drive == {{(ROW_DRIVE_W-1){1'b1}}, 1'b0})
		else $error("power event outside sweep end");

	// a slot waiting on a full result register is kept, not dropped
	a_slot_held : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(column_pins_s1))
		else $error("stalled scan slot lost");

	// a result the sink has not taken stays in place
	a_result_held : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !scan_out.ready |=> out_valid_q && $stable(result_q))
		else $error("stalled result changed");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the keypad scanner: scan slots in, result words out
// ----------------------------------------------------------------------------
// Scan slots are pushed through the valid/ready input channel and every result
// word is checked, field by field, against a scan-state predictor kept in the
// bench. A short table of directed slots comes first. Random key-press
// episodes follow, under several register settings and idle patterns, ending
// with a zero debounce setting.
// ----------------------------------------------------------------------------
module tb import mks_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS        = 5;
	localparam int COUNT_BITS  = 16;
	localparam int LATENCY     = 2;          // input register + result register
	localparam int CYCLE_LIMIT = 200_000;
	localparam int HOLD_OFF    = 40;         // long receiver stall, in cycles
	localparam int MAX_REPORTS = 10;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [CFG_IDX_W-1:0]  CFG_UNMAPPED = 2'd3;
	localparam logic [COL_W-1:0]      NO_COLUMN = '1;

	// matrix index to position code, as wired on the board
	localparam logic [KEY_W-1:0] POSITION_CODE [CODE_TABLE_LEN] = '{
		5'd0,  5'd11, 5'd6,  5'd1,  5'd16,
		5'd5,  5'd12, 5'd7,  5'd2,  5'd9,
		5'd10, 5'd13, 5'd8,  5'd3,  5'd17,
		5'd15, 5'd18, 5'd14, 5'd4,  5'd19
	};

	typedef struct packed {
		logic [COL_W-1:0] cols;
		logic             pwr;
		logic             typed;   // want holds a hand-written result word
		result_t          want;
	} slot_row_t;

	// debounce and power hold are both 1 while this table runs
	localparam int DIRECTED_LEN = 20;
	localparam slot_row_t DIRECTED [DIRECTED_LEN] = '{
		// first sweep: key at column 3 / row 4 seen once, power pressed
		'{4'b1111, 1'b1, 1'b1, '{5'h1D, 1'b0, 5'd0, 1'b0}},
		'{4'b1111, 1'b1, 1'b1, '{5'h1B, 1'b0, 5'd0, 1'b0}},
		'{4'b1111, 1'b1, 1'b1, '{5'h17, 1'b0, 5'd0, 1'b0}},
		'{4'b1111, 1'b1, 1'b1, '{5'h0F, 1'b0, 5'd0, 1'b0}},
		'{4'b0111, 1'b1, 1'b1, '{5'h1E, 1'b0, 5'd0, 1'b0}},
		// second sweep: same key matches once, code 19 goes out
		'{4'b1111, 1'b1, 1'b0, '0},
		'{4'b1111, 1'b1, 1'b0, '0},
		'{4'b1111, 1'b1, 1'b0, '0},
		'{4'b1111, 1'b1, 1'b0, '0},
		'{4'b0111, 1'b1, 1'b1, '{5'h1E, 1'b1, 5'd19, 1'b0}},
		// third sweep: only ghosting and empty slots, power now past hold
		'{4'b0000, 1'b1, 1'b0, '0},
		'{4'b1111, 1'b1, 1'b0, '0},
		'{4'b1010, 1'b1, 1'b0, '0},
		'{4'b0000, 1'b1, 1'b0, '0},
		'{4'b1111, 1'b1, 1'b1, '{5'h1E, 1'b0, 5'd0, 1'b1}},
		// fourth sweep: later captures overwrite earlier ones, power released
		'{4'b1110, 1'b0, 1'b0, '0},
		'{4'b1101, 1'b0, 1'b0, '0},
		'{4'b1111, 1'b0, 1'b0, '0},
		'{4'b1011, 1'b0, 1'b0, '0},
		'{4'b1111, 1'b0, 1'b0, '0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mks_in_if  scan_in_if ();
	mks_out_if scan_out_if ();

	matrix_keypad_scanner_debounce uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.scan_in  (scan_in_if.sink),
		.scan_out (scan_out_if.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predicted scan state and register copy
	cfg_t                  model_cfg;
	logic [2:0]            p_scan_row;
	logic [KEY_W-1:0]      p_sample_key;
	logic                  p_sample_present;
	logic [KEY_W-1:0]      p_stable_key;
	logic                  p_stable_present;
	logic [COUNT_BITS-1:0] p_match_count;
	logic                  p_power_seen;
	logic [COUNT_BITS-1:0] p_power_count;

	result_t pending_results [$];

	// bench knobs shared between the sender and receiver processes
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_off_req  = 0;

	int mismatches     = 0;
	int slots_sent     = 0;
	int settings_used  = 0;
	int key_codes_seen = 0;
	int power_evs_seen = 0;
	int cycle_count    = 0;

	function automatic logic [KEY_W-1:0] key_position(logic [KEY_W-1:0] idx);
		return (idx < CODE_TABLE_LEN) ? POSITION_CODE[idx] : idx;
	endfunction

	// one scan slot: capture, end-of-sweep debounce and power hold, next row
	function automatic result_t scan_slot_predict(logic [COL_W-1:0] cols, logic pwr);
		logic [COL_W-1:0] active;
		result_t          res;
		active = ~cols;
		res = '0;
		for (int c = 0; c < COLUMNS; c++) begin
			if (active == (COL_W'(1) << c)) begin
				p_sample_key     = KEY_W'(c * ROWS + p_scan_row);
				p_sample_present = 1'b1;
			end
		end
		if (p_scan_row == 3'(ROWS - 1)) begin
			if (!p_sample_present) begin
				p_stable_present = 1'b0;
				p_stable_key     = '0;
				p_match_count    = '0;
			end else if (p_stable_present && p_sample_key == p_stable_key) begin
				if (p_match_count != COUNT_MAX)
					p_match_count = p_match_count + 1'b1;
				if (p_match_count == model_cfg.debounce_sweeps && model_cfg.key_enable) begin
					res.key_event = 1'b1;
					res.key_code  = key_position(p_sample_key);
				end
			end else begin
				p_stable_key     = p_sample_key;
				p_stable_present = 1'b1;
				p_match_count    = '0;
			end
			p_sample_present = 1'b0;
			p_sample_key     = '0;
			if (pwr) begin
				if (p_power_seen) begin
					if (p_power_count != COUNT_MAX)
						p_power_count = p_power_count + 1'b1;
					if (p_power_count > model_cfg.power_hold_sweeps)
						res.power_event = 1'b1;
				end else begin
					p_power_seen  = 1'b1;
					p_power_count = '0;
				end
			end else begin
				p_power_seen  = 1'b0;
				p_power_count = '0;
			end
		end
		p_scan_row    = (p_scan_row == 3'(ROWS - 1)) ? 3'd0 : p_scan_row + 1'b1;
		res.row_drive = ~(ROW_DRIVE_W'(1) << p_scan_row);
		return res;
	endfunction

	// offer one slot, wait for the handshake, then book its expected word
	task automatic send_slot(input logic [COL_W-1:0] cols, input logic pwr,
			input logic typed, input result_t want);
		result_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			scan_in_if.valid <= 1'b0;
			@(posedge clk);
		end
		scan_in_if.valid       <= 1'b1;
		scan_in_if.column_pins <= cols;
		scan_in_if.power_pin   <= pwr;
		do @(posedge clk); while (!scan_in_if.ready);
		res = scan_slot_predict(cols, pwr);
		pending_results.push_back(typed ? want : res);
		slots_sent++;
	endtask

	// stop offering and wait until every booked word has come back
	task automatic drain();
		scan_in_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// all three registers plus a write to the unmapped index, which is dropped
	task automatic cfg_apply(input logic en, input logic [CFG_DATA_W-1:0] debounce,
			input logic [CFG_DATA_W-1:0] hold);
		cfg_write <= 1'b1;
		cfg_index <= CFG_KEY_ENABLE;
		cfg_data  <= CFG_DATA_W'(en);
		@(posedge clk);
		cfg_index <= CFG_DEBOUNCE_SWEEPS;
		cfg_data  <= debounce;
		@(posedge clk);
		cfg_index <= CFG_POWER_HOLD_SWEEPS;
		cfg_data  <= hold;
		@(posedge clk);
		cfg_index <= CFG_UNMAPPED;
		cfg_data  <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_write <= 1'b0;
		model_cfg.key_enable        = en;
		model_cfg.debounce_sweeps   = debounce;
		model_cfg.power_hold_sweeps = hold;
		settings_used++;
	endtask

	// key-press episodes: one key held for a few sweeps, with some noise slots
	task automatic run_random(input int count, input int hold_at, input int pause_at);
		int          sent;
		int          sweeps;
		int          max_sweeps;
		logic [2:0]  key_row;
		logic [1:0]  key_col;
		logic        pwr;
		logic        no_key;
		logic [COL_W-1:0] cols;
		sent = 0;
		max_sweeps = ((model_cfg.debounce_sweeps > model_cfg.power_hold_sweeps) ?
			int'(model_cfg.debounce_sweeps) : int'(model_cfg.power_hold_sweeps)) + 3;
		while (sent < count) begin
			key_row = 3'($urandom_range(0, ROWS - 1));
			key_col = 2'($urandom_range(0, COLUMNS - 1));
			pwr     = 1'($urandom_range(0, 1));
			no_key  = ($urandom_range(0, 9) == 0);
			sweeps  = $urandom_range(1, max_sweeps);
			for (int s = 0; s < sweeps * ROWS; s++) begin
				cols = (!no_key && p_scan_row == key_row) ? ~(COL_W'(1) << key_col) : NO_COLUMN;
				if ($urandom_range(0, 9) == 0)
					cols = COL_W'($urandom_range(0, 15));
				send_slot(cols, pwr ^ ($urandom_range(0, 19) == 0), 1'b0, '0);
				sent++;
				// output side stalls for a long stretch, input backs up
				if (sent == hold_at)
					hold_off_req = HOLD_OFF;
				// input side goes quiet until all results are back
				if (sent == pause_at) begin
					scan_in_if.valid <= 1'b0;
					while (pending_results.size() != 0)
						@(posedge clk);
				end
			end
		end
	endtask

	// result side: check accepted words, then pick ready for the next edge
	initial begin
		int      hold_left;
		result_t got;
		result_t want;
		hold_left = 0;
		scan_out_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (scan_out_if.valid && scan_out_if.ready) begin
				got = '{scan_out_if.row_drive, scan_out_if.key_event,
					scan_out_if.key_code, scan_out_if.power_event};
				if (got.key_event)   key_codes_seen++;
				if (got.power_event) power_evs_seen++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected word row=%h key=%b code=%0d pwr=%b",
							$realtime, got.row_drive, got.key_event, got.key_code,
							got.power_event);
				end else begin
					want = pending_results.pop_front();
					if (got.row_drive !== want.row_drive || got.key_event !== want.key_event ||
							got.key_code !== want.key_code ||
							got.power_event !== want.power_event) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$write("%0t: mismatch row=%h/%h key=%b/%b", $realtime,
								want.row_drive, got.row_drive, want.key_event,
								got.key_event);
							$display(" code=%0d/%0d pwr=%b/%b (expected/actual)",
								want.key_code, got.key_code, want.power_event,
								got.power_event);
						end
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				scan_out_if.ready <= 1'b0;
			end else if (hold_off_req > 0) begin
				hold_left    = hold_off_req - 1;
				hold_off_req = 0;
				scan_out_if.ready <= 1'b0;
			end else begin
				scan_out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n                 = 1'b0;
		cfg_write              = 1'b0;
		cfg_index              = CFG_KEY_ENABLE;
		cfg_data               = '0;
		scan_in_if.valid       = 1'b0;
		scan_in_if.column_pins = NO_COLUMN;
		scan_in_if.power_pin   = 1'b0;

		// register and scan state after reset
		model_cfg.key_enable        = 1'b1;
		model_cfg.debounce_sweeps   = 16'd8;
		model_cfg.power_hold_sweeps = 16'd200;
		p_scan_row       = '0;
		p_sample_key     = '0;
		p_sample_present = 1'b0;
		p_stable_key     = '0;
		p_stable_present = 1'b0;
		p_match_count    = '0;
		p_power_seen     = 1'b0;
		p_power_count    = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table, shortest debounce and power hold, no idling
		cfg_apply(1'b1, 16'd1, 16'd1);
		for (int i = 0; i < DIRECTED_LEN; i++)
			send_slot(DIRECTED[i].cols, DIRECTED[i].pwr, DIRECTED[i].typed, DIRECTED[i].want);
		drain();

		// sender sparse, receiver mostly stalled, one long receiver hold-off
		send_idle_pct = 27;
		recv_idle_pct = 63;
		cfg_apply(1'b1, 16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)));
		run_random(170, 80, -1);
		drain();

		// roles swapped, key codes disabled, sender pauses midway
		send_idle_pct = 63;
		recv_idle_pct = 27;
		cfg_apply(1'b0, 16'($urandom_range(1, 3)), 16'd1);
		run_random(170, -1, 100);
		drain();

		// back to back on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		cfg_apply(1'b1, 16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)));
		run_random(170, -1, -1);
		drain();

		// zero debounce: the counter never lands on it, so no key codes
		cfg_apply(1'b1, 16'd0, 16'($urandom_range(1, 3)));
		run_random(40, -1, -1);
		drain();

		$display("run covered %0d scan slots under %0d register settings",
			slots_sent, settings_used);
		$display("saw %0d debounced key codes and %0d power hold events, %0d mismatches",
			key_codes_seen, power_evs_seen, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/mks_pkg.sv
src/mks_in_if.sv
src/mks_out_if.sv
src/mks_cfg_regs.sv
src/mks_scan_core.sv
src/matrix_keypad_scanner_debounce.sv
bench/tb.sv
